@@ rtl/owbm_pkg.sv @@
// owbm_pkg: shared types and constants for the single-wire bus master
`timescale 1ns / 1ps

package owbm_pkg;

  // timer width for phase counting
  localparam int unsigned TimerBits = 20;

  // configuration register widths
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 20;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_RESET_RELEASE = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SLOT          = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_WINK          = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_SAMPLE        = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_RECOVERY      = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_PULLUP        = 3'd6;

  // command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_RESET  = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_PULLUP = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_REL  = 3'd2,
    PH_WINK     = 3'd3,
    PH_SLOT     = 3'd4,
    PH_ZERO_LOW = 3'd5,
    PH_RECOVER  = 3'd6,
    PH_PULLUP   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       line_in;
    logic [7:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       strong_high;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rejected;
  } out_t;

endpackage

@@ rtl/one_wire_bus_master.sv @@
// one_wire_bus_master: single-wire bus master stepped by tick and command transactions
//
//   channel  direction  signals                               payload
//   in       sink       in_valid_i, in_stall_o, in_data_i     in_t  (cmd, line_in, tx_byte)
//   out      source     out_valid_o, out_stall_i, out_data_o  out_t (one result per input)
//   cfg      sink       cfg_we_i, cfg_idx_i, cfg_wdata_i      seven timing registers
//
// one input transaction per cycle while in_stall_o is low; its result is registered in the output stage
// the whole step (command decode, phase counter compare, shift) sits between the state
// registers and the result register, so the rate is one per cycle unless input stalls
// a two-entry output stage (result register plus skid register) lets input continue while
// a result waits; input stalls only once the skid register is occupied
// reset clears the state machine and loads the timing registers with their defaults
`timescale 1ns / 1ps

module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_t                   out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  // timing registers
  logic [9:0]           rst_low_q, rst_rel_q;
  logic [7:0]           slot_q;
  logic [3:0]           wink_q, sample_q, recov_q;
  logic [TimerBits-1:0] pullup_q;

  // bus state
  phase_e               phase_q, phase_d;
  logic                 reading_q, reading_d;
  logic [TimerBits-1:0] tick_q, tick_d;
  logic [2:0]           bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;

  // state after a command has been taken on an idle item
  phase_e               ph_cur;
  logic                 rd_cur;
  logic [7:0]           sr_cur;
  logic                 is_cmd;

  logic [TimerBits-1:0] len_raw, len_m1, sample_at;
  logic                 bit_end, finish;
  logic [7:0]           sr_next;

  out_t res;

  // output stage
  logic in_acc, out_ready;
  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign is_cmd     = (in_data_i.cmd >= CMD_RESET) && (in_data_i.cmd <= CMD_PULLUP);

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q <= 10'd500;
      rst_rel_q <= 10'd500;
      slot_q    <= 8'd60;
      wink_q    <= 4'd2;
      sample_q  <= 4'd3;
      recov_q   <= 4'd1;
      pullup_q  <= TimerBits'(750000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_LOW:     rst_low_q <= cfg_wdata_i[9:0];
        CFG_RESET_RELEASE: rst_rel_q <= cfg_wdata_i[9:0];
        CFG_SLOT:          slot_q    <= cfg_wdata_i[7:0];
        CFG_WINK:          wink_q    <= cfg_wdata_i[3:0];
        CFG_SAMPLE:        sample_q  <= cfg_wdata_i[3:0];
        CFG_RECOVERY:      recov_q   <= cfg_wdata_i[3:0];
        CFG_PULLUP:        pullup_q  <= cfg_wdata_i[TimerBits-1:0];
        default: ;
      endcase
    end
  end

  // command start: an accepted command on an idle item is already the first tick
  always_comb begin
    ph_cur = phase_q;
    rd_cur = reading_q;
    sr_cur = shift_q;
    if (phase_q == PH_IDLE && is_cmd) begin
      rd_cur = 1'b0;
      unique case (in_data_i.cmd)
        CMD_RESET: ph_cur = PH_RST_LOW;
        CMD_WRITE: begin
          sr_cur = in_data_i.tx_byte;
          ph_cur = in_data_i.tx_byte[0] ? PH_WINK : PH_ZERO_LOW;
        end
        CMD_READ: begin
          rd_cur = 1'b1;
          sr_cur = 8'h00;
          ph_cur = PH_WINK;
        end
        default: ph_cur = PH_PULLUP;
      endcase
    end
  end

  // phase length, zero counts as one item
  always_comb begin
    unique case (ph_cur)
      PH_RST_LOW:           len_raw = TimerBits'(rst_low_q);
      PH_RST_REL:           len_raw = TimerBits'(rst_rel_q);
      PH_WINK:              len_raw = TimerBits'(wink_q);
      PH_SLOT, PH_ZERO_LOW: len_raw = TimerBits'(slot_q);
      PH_RECOVER:           len_raw = TimerBits'(recov_q);
      default:              len_raw = pullup_q;
    endcase
    len_m1    = (len_raw == '0) ? '0 : len_raw - 1'b1;
    sample_at = (TimerBits'(sample_q) > len_m1) ? len_m1 : TimerBits'(sample_q);
  end

  // next state
  always_comb begin
    phase_d   = ph_cur;
    reading_d = rd_cur;
    tick_d    = tick_q;
    bit_d     = bit_q;
    sr_next   = sr_cur;
    bit_end   = 1'b0;
    finish    = 1'b0;
    if (phase_q == PH_IDLE && is_cmd) begin
      tick_d = '0;
      bit_d  = '0;
    end
    if (ph_cur != PH_IDLE) begin
      // read sample inside the released part of the slot
      if (ph_cur == PH_SLOT && rd_cur && tick_d == sample_at) begin
        sr_next = {in_data_i.line_in, sr_cur[7:1]};
      end
      if (tick_d >= len_m1) begin
        tick_d = '0;
        unique case (ph_cur)
          PH_RST_LOW:            phase_d = PH_RST_REL;
          PH_WINK:               phase_d = PH_SLOT;
          PH_ZERO_LOW:           phase_d = PH_RECOVER;
          PH_SLOT, PH_RECOVER:   bit_end = 1'b1;
          default:               finish  = 1'b1;
        endcase
        if (bit_end) begin
          if (!rd_cur) begin
            sr_next = {1'b0, sr_next[7:1]};
          end
          if (bit_q == 3'd7) begin
            finish = 1'b1;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = (rd_cur || sr_next[0]) ? PH_WINK : PH_ZERO_LOW;
          end
        end
      end else begin
        tick_d = tick_d + 1'b1;
      end
      if (finish) begin
        phase_d = PH_IDLE;
        tick_d  = '0;
        bit_d   = '0;
      end
    end
    shift_d = sr_next;
  end

  // result of this item
  always_comb begin
    res             = '0;
    res.rejected    = (phase_q != PH_IDLE) && is_cmd;
    res.drive_low   = (ph_cur == PH_RST_LOW) || (ph_cur == PH_WINK) ||
                      (ph_cur == PH_ZERO_LOW);
    res.strong_high = (ph_cur == PH_PULLUP);
    res.busy_res    = (phase_d != PH_IDLE);
    res.done_res    = finish;
    res.rx_byte     = (finish && rd_cur) ? sr_next : 8'h00;
  end

  // state registers advance once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      reading_q <= 1'b0;
      tick_q    <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      reading_q <= reading_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
    end
  end

  // output register with skid stage, control part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output register with skid stage, payload part
  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output register is empty");

  // a finishing item never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done and busy reported together");

  // counters rest at zero while idle
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (tick_q == '0 && bit_q == '0))
    else $error("phase counter or bit index left over in idle");

  // bit index only moves during byte transfers
  a_bit_in_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_q != '0) |-> (phase_q == PH_WINK || phase_q == PH_SLOT ||
                        phase_q == PH_ZERO_LOW || phase_q == PH_RECOVER))
    else $error("bit index set outside a byte transfer");

  // a command is rejected only while the bus state machine is busy
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.rejected) |-> (phase_q != PH_IDLE))
    else $error("command rejected while idle");

endmodule

@@ dv/tb_one_wire_bus_master.sv @@
// tb_one_wire_bus_master: self-checking testbench for the single-wire bus master
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
  import owbm_pkg::*;

  // register index past the end of the list, writes to it must be ignored
  localparam logic [CfgIdxBits-1:0] CFG_UNUSED = 3'd7;
  // command codes outside the defined set behave as plain ticks
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  // minimum number of transactions sent over the whole run, directed part included
  localparam int unsigned TotalItems = 1450;
  // cap on printed mismatch lines, all mismatches are still counted
  localparam int unsigned PrintCap = 60;

  // tracks the bus master state and queues the result of every accepted transaction
  class bus_scoreboard;
    logic [9:0]           rst_low_len;
    logic [9:0]           rst_rel_len;
    logic [7:0]           slot_len;
    logic [3:0]           wink_len;
    logic [3:0]           sample_at;
    logic [3:0]           recover_len;
    logic [19:0]          pullup_len;
    phase_e               phase;
    bit                   reading;
    logic [TimerBits-1:0] tick_count;
    logic [2:0]           bit_index;
    logic [7:0]           shift_reg;
    out_t                 bus_results_q[$];
    int unsigned          mismatches;

    function new();
      rst_low_len = 10'd500;
      rst_rel_len = 10'd500;
      slot_len    = 8'd60;
      wink_len    = 4'd2;
      sample_at   = 4'd3;
      recover_len = 4'd1;
      pullup_len  = 20'd750000;
      phase       = PH_IDLE;
      reading     = 1'b0;
      tick_count  = '0;
      bit_index   = '0;
      shift_reg   = '0;
      mismatches  = 0;
    endfunction

    task report(string what);
      if (mismatches < PrintCap) $display("ERROR %0t ns: %s", $time, what);
      mismatches++;
    endtask

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_RESET_LOW:     rst_low_len = data[9:0];
        CFG_RESET_RELEASE: rst_rel_len = data[9:0];
        CFG_SLOT:          slot_len    = data[7:0];
        CFG_WINK:          wink_len    = data[3:0];
        CFG_SAMPLE:        sample_at   = data[3:0];
        CFG_RECOVERY:      recover_len = data[3:0];
        CFG_PULLUP:        pullup_len  = data[19:0];
        default: ;
      endcase
    endfunction

    function bit bus_busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return bus_results_q.size();
    endfunction

    // zero-length phases last one tick, lengths clip at the timer range
    function longint unsigned phase_len(phase_e ph);
      longint unsigned n;
      case (ph)
        PH_RST_LOW:           n = rst_low_len;
        PH_RST_REL:           n = rst_rel_len;
        PH_WINK:              n = wink_len;
        PH_SLOT, PH_ZERO_LOW: n = slot_len;
        PH_RECOVER:           n = recover_len;
        default:              n = pullup_len;
      endcase
      if (n == 0) n = 1;
      if (n > (64'd1 << TimerBits)) n = 64'd1 << TimerBits;
      return n;
    endfunction

    function void enter_phase(phase_e ph);
      phase      = ph;
      tick_count = '0;
    endfunction

    // reads and one bits open with a wink, zero bits hold the line for a slot
    function void start_bit();
      if (reading || shift_reg[0]) enter_phase(PH_WINK);
      else enter_phase(PH_ZERO_LOW);
    endfunction

    function out_t predict_bus_step(in_t it);
      out_t            r;
      bit              is_cmd;
      bit              finish;
      bit              bit_end;
      longint unsigned len;
      longint unsigned at;
      longint unsigned tc;
      r      = '0;
      is_cmd = (it.cmd >= CMD_RESET) && (it.cmd <= CMD_PULLUP);
      if (phase == PH_IDLE) begin
        if (is_cmd) begin
          bit_index = '0;
          reading   = 1'b0;
          case (it.cmd)
            CMD_RESET: enter_phase(PH_RST_LOW);
            CMD_WRITE: begin
              shift_reg = it.tx_byte;
              start_bit();
            end
            CMD_READ: begin
              reading   = 1'b1;
              shift_reg = '0;
              start_bit();
            end
            default: enter_phase(PH_PULLUP);
          endcase
        end
      end else if (is_cmd) begin
        r.rejected = 1'b1;
      end

      if (phase != PH_IDLE) begin
        len     = phase_len(phase);
        finish  = 1'b0;
        bit_end = 1'b0;
        tc      = tick_count;
        r.drive_low   = (phase == PH_RST_LOW) || (phase == PH_WINK) || (phase == PH_ZERO_LOW);
        r.strong_high = (phase == PH_PULLUP);
        // a sample point beyond the slot falls back to its last tick
        if (phase == PH_SLOT && reading) begin
          at = sample_at;
          if (at > len - 1) at = len - 1;
          if (tc == at) shift_reg = {it.line_in, shift_reg[7:1]};
        end
        if (tc + 1 >= len) begin
          case (phase)
            PH_RST_LOW:          enter_phase(PH_RST_REL);
            PH_WINK:             enter_phase(PH_SLOT);
            PH_ZERO_LOW:         enter_phase(PH_RECOVER);
            PH_SLOT, PH_RECOVER: bit_end = 1'b1;
            default:             finish = 1'b1;
          endcase
          if (bit_end) begin
            if (!reading) shift_reg = shift_reg >> 1;
            if (bit_index == 3'd7) begin
              finish = 1'b1;
            end else begin
              bit_index++;
              start_bit();
            end
          end
        end else begin
          tick_count++;
        end
        if (finish) begin
          r.done_res = 1'b1;
          if (reading) r.rx_byte = shift_reg;
          phase      = PH_IDLE;
          tick_count = '0;
          bit_index  = '0;
        end
      end
      r.busy_res = (phase != PH_IDLE);
      return r;
    endfunction

    // queues the predicted result of an accepted transaction
    function void note_item(in_t it);
      bus_results_q.push_back(predict_bus_step(it));
    endfunction

    task check_result(out_t got);
      out_t want;
      if (bus_results_q.size() == 0) begin
        report($sformatf("result %h with no transaction outstanding", got));
        return;
      end
      want = bus_results_q.pop_front();
      if (got.drive_low !== want.drive_low)
        report($sformatf("drive_low %b, expected %b", got.drive_low, want.drive_low));
      if (got.strong_high !== want.strong_high)
        report($sformatf("strong_high %b, expected %b", got.strong_high, want.strong_high));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
      if (got.rx_byte !== want.rx_byte)
        report($sformatf("rx_byte %h, expected %h", got.rx_byte, want.rx_byte));
      if (got.rejected !== want.rejected)
        report($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
    endtask
  endclass

  // all block inputs start at known values
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  in_t                    in_data_i   = '0;
  logic                   out_stall_i = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i   = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  out_t                   out_data_o;

  bus_scoreboard sb = new();

  // sender runs in bursts without gaps now and then
  bit          send_burst = 1'b0;
  // transactions accepted so far over the whole run
  int unsigned sent_items = 0;

  always #2 clk_i = ~clk_i;

  one_wire_bus_master u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // one input transaction: optional gap, then hold valid and payload until accepted
  // valid stays high into the next call when that one draws no gap
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] tx, input logic line);
    in_t         it;
    int unsigned gap;
    it.cmd     = cmd;
    it.line_in = line;
    it.tx_byte = tx;
    if (!send_burst && $urandom_range(0, 59) == 0) send_burst = 1'b1;
    else if (send_burst && $urandom_range(0, 39) == 0) send_burst = 1'b0;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    sent_items++;
  endtask

  // a tick while an operation runs, sometimes carrying a stray command
  task automatic send_tick();
    logic [2:0] cmd;
    cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(CMD_RESET, CMD_SPARE_HI)) : CMD_TICK;
    send_item(cmd, 8'($urandom), 1'($urandom));
  endtask

  // register writes only once every result is back and the datapath has drained
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // start one command, optionally retime a register part way through, tick until idle
  task automatic run_op(input logic [2:0] cmd, input logic [7:0] tx, input bit retime);
    int unsigned n;
    send_item(cmd, tx, 1'($urandom));
    if (retime) begin
      n = $urandom_range(0, 6);
      while (n != 0 && sb.bus_busy()) begin
        send_tick();
        n--;
      end
      write_reg(3'($urandom_range(CFG_RESET_LOW, CFG_PULLUP)), 20'($urandom_range(0, 6)));
    end
    while (sb.bus_busy()) send_tick();
  endtask

  // a register at its maximum, with garbage above its width, then cut short mid-phase
  task automatic long_phase(input logic [CfgIdxBits-1:0] idx, input logic [2:0] cmd,
                            input logic [7:0] tx);
    write_reg(idx, '1);
    send_item(cmd, tx, 1'($urandom));
    repeat (40) if (sb.bus_busy()) send_tick();
    write_reg(idx, 20'd2);
    while (sb.bus_busy()) send_tick();
  endtask

  // random timing set, with all-zero and all-max short fields among the draws
  task automatic random_config();
    int unsigned mode;
    logic [9:0]  rl;
    logic [9:0]  rr;
    logic [7:0]  sl;
    logic [3:0]  wk;
    logic [3:0]  sp;
    logic [3:0]  rc;
    logic [19:0] pu;
    mode = $urandom_range(0, 7);
    rl   = 10'($urandom_range(0, 24));
    rr   = 10'($urandom_range(0, 24));
    sl   = 8'($urandom_range(0, 12));
    wk   = 4'($urandom_range(0, 4));
    sp   = 4'($urandom_range(0, 15));
    rc   = 4'($urandom_range(0, 4));
    pu   = 20'($urandom_range(0, 40));
    if (mode == 0) begin
      rl = '0; rr = '0; sl = '0; wk = '0; sp = '0; rc = '0; pu = '0;
    end else if (mode == 1) begin
      wk = 4'hF; sp = 4'hF; rc = 4'hF;
    end else if (mode == 2) begin
      wk = 4'($urandom);
      rc = 4'($urandom);
    end
    write_reg(CFG_RESET_LOW,     {10'($urandom), rl});
    write_reg(CFG_RESET_RELEASE, {10'($urandom), rr});
    write_reg(CFG_SLOT,          {12'($urandom), sl});
    write_reg(CFG_WINK,          {16'($urandom), wk});
    write_reg(CFG_SAMPLE,        {16'($urandom), sp});
    write_reg(CFG_RECOVERY,      {16'($urandom), rc});
    write_reg(CFG_PULLUP,        pu);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 20'($urandom));
  endtask

  initial begin : stimulus
    int unsigned ops;
    int unsigned pick;
    logic [2:0]  cmd;
    logic [7:0]  tx;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: idle ticks and spare codes do nothing, then the default
    // reset low time of 500 ticks runs out and the release is cut short
    send_item(CMD_TICK, 8'hFF, 1'b1);
    send_item(CMD_SPARE_HI, 8'h00, 1'b0);
    send_item(CMD_RESET, 8'h00, 1'b1);
    repeat (505) if (sb.bus_busy()) send_tick();
    write_reg(CFG_RESET_RELEASE, 20'd4);
    while (sb.bus_busy()) send_tick();
    send_item(CMD_PULLUP, 8'h00, 1'b0);
    repeat (20) if (sb.bus_busy()) send_tick();
    write_reg(CFG_PULLUP, 20'd3);
    while (sb.bus_busy()) send_tick();

    // directed: every phase at its shortest, commands refused while busy,
    // spare codes while busy and while idle
    write_reg(CFG_RESET_LOW, '0);
    write_reg(CFG_RESET_RELEASE, '0);
    write_reg(CFG_SLOT, '0);
    write_reg(CFG_WINK, '0);
    write_reg(CFG_SAMPLE, '0);
    write_reg(CFG_RECOVERY, '0);
    write_reg(CFG_PULLUP, '0);
    send_item(CMD_WRITE, 8'hA5, 1'b1);
    send_item(CMD_READ, 8'h00, 1'b0);
    send_item(CMD_SPARE_HI, 8'hFF, 1'b1);
    send_item(CMD_RESET, 8'h00, 1'b0);
    send_item(CMD_PULLUP, 8'hFF, 1'b1);
    while (sb.bus_busy()) send_tick();
    run_op(CMD_READ, 8'hFF, 1'b0);
    run_op(CMD_RESET, 8'h00, 1'b0);
    run_op(CMD_PULLUP, 8'h00, 1'b0);
    send_item(CMD_SPARE_LO, 8'h5A, 1'b0);

    // maximum register values, each phase cut short once it is well under way
    long_phase(CFG_RESET_LOW, CMD_RESET, 8'h00);
    long_phase(CFG_RESET_RELEASE, CMD_RESET, 8'h00);
    long_phase(CFG_SLOT, CMD_READ, 8'h00);
    long_phase(CFG_SLOT, CMD_WRITE, 8'h00);
    long_phase(CFG_PULLUP, CMD_PULLUP, 8'h00);
    write_reg(CFG_UNUSED, '1);

    // random part: new timing per round, then a few operations with stray
    // commands and idle ticks between them, until the run reaches its item count
    while (sent_items < TotalItems) begin
      random_config();
      ops = $urandom_range(1, 4);
      repeat (ops) begin
        repeat ($urandom_range(0, 2)) begin
          cmd = ($urandom_range(0, 1) == 0) ? CMD_TICK :
                3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          send_item(cmd, 8'($urandom), 1'($urandom));
        end
        pick = $urandom_range(0, 19);
        if (pick < 7) cmd = CMD_WRITE;
        else if (pick < 14) cmd = CMD_READ;
        else if (pick < 17) cmd = CMD_RESET;
        else cmd = CMD_PULLUP;
        case ($urandom_range(0, 9))
          0:       tx = 8'h00;
          1:       tx = 8'hFF;
          default: tx = 8'($urandom);
        endcase
        run_op(cmd, tx, $urandom_range(0, 7) == 0);
      end
    end

    // drain, then wait a margin for any result still in the output stage
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end of run");
    if (sb.mismatches == 0) begin
      $display("PASS one_wire_bus_master");
    end else begin
      $display("FAIL one_wire_bus_master");
    end
    $finish;
  end

  // result side: check every accepted result, then hold stall for a random count
  initial begin : result_sink
    int unsigned hold;
    bit          recv_burst;
    recv_burst = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        if (!recv_burst && $urandom_range(0, 59) == 0) recv_burst = 1'b1;
        else if (recv_burst && $urandom_range(0, 39) == 0) recv_burst = 1'b0;
        hold = recv_burst ? 0 : $urandom_range(0, 10);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // hang guard, many times the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAIL one_wire_bus_master");
    $finish;
  end

endmodule

@@ files.f @@
rtl/owbm_pkg.sv
rtl/one_wire_bus_master.sv
dv/tb_one_wire_bus_master.sv
